/* hw/rtl/dtpc_pkg.sv */
// ----------------------------------------------------------------------------
// dtpc_pkg
// Shared sizes, command codes and field widths of the digit trie counter.
// ----------------------------------------------------------------------------
package dtpc_pkg;

    localparam int NODE_COUNT = 65536;
    localparam int COUNT_BITS = 16;
    localparam int RADIX      = 10;

    localparam int NODE_BITS  = $clog2(NODE_COUNT);
    localparam int USED_BITS  = NODE_BITS + 1;
    localparam int PTR_DEPTH  = NODE_COUNT * RADIX;
    localparam int PTR_BITS   = $clog2(PTR_DEPTH);
    localparam int ROW_BITS   = RADIX + COUNT_BITS;

    localparam int CMD_BITS   = 2;
    localparam int DIGIT_BITS = 4;

    localparam logic [DIGIT_BITS-1:0] DIGIT_MAX = DIGIT_BITS'(RADIX - 1);

    typedef enum logic [CMD_BITS-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

endpackage

/* hw/rtl/dtpc_in_if.sv */
// ----------------------------------------------------------------------------
// dtpc_in_if
// Digit command channel: valid/ready with command, digit and end flag.
// ----------------------------------------------------------------------------
interface dtpc_in_if
    import dtpc_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CMD_BITS-1:0]   cmd;
    logic [DIGIT_BITS-1:0] digit;
    logic                  last;

    modport source (output valid, output cmd, output digit, output last, input ready);
    modport sink   (input valid, input cmd, input digit, input last, output ready);
endinterface

/* hw/rtl/dtpc_out_if.sv */
// ----------------------------------------------------------------------------
// dtpc_out_if
// Result channel: valid/ready with found, unique and overflow flags.
// ----------------------------------------------------------------------------
interface dtpc_out_if;
    logic valid;
    logic ready;
    logic found;
    logic unique_res;
    logic overflow;

    modport source (output valid, output found, output unique_res, output overflow,
                    input ready);
    modport sink   (input valid, input found, input unique_res, input overflow,
                    output ready);
endinterface

/* hw/rtl/digit_trie_prefix_counter.sv */
// ----------------------------------------------------------------------------
// digit_trie_prefix_counter
// Decimal digit trie in a node pool; counts prefixes on insert, answers
// path-exists / count-is-one results on the final digit of an insert or query string.
// ----------------------------------------------------------------------------
//
//  channel | dir | beat contents                  | notes
//  --------+-----+--------------------------------+-------------------------
//  din     | in  | cmd, digit, last               | one digit per beat
//  dout    | out | found, unique_res, overflow    | only on last insert/query
//
//  Steps: a digit that follows an existing child passes ST_IDLE (pointer
//  read), ST_PTR (child row read) and ST_ROW (write-back); an allocating
//  digit passes ST_IDLE and ST_ALLOC; clear, a dropped digit or a missing
//  path ends in ST_IDLE. The dependent pointer and row reads need ST_PTR and ST_ROW.
//  Reset: control state clears at once; the root row lives in flops, so no
//  memory clearing pass is needed and clear only resets flops.
//  Stalls: a result waits in the output register while the next beat is
//  taken; a second result behind it is parked and din is held off.
//
module digit_trie_prefix_counter
    import dtpc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    dtpc_in_if.sink    din,
    dtpc_out_if.source dout
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PTR,
        ST_ROW,
        ST_ALLOC,
        ST_HOLD
    } state_t;

    // saturating increment of a prefix count
    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        sat_inc = (c == {COUNT_BITS{1'b1}}) ? c : c + COUNT_BITS'(1);
    endfunction

    // memories: child pointers, and node rows {present bits, count}
    logic [NODE_BITS-1:0] ptr_mem [PTR_DEPTH];
    logic [ROW_BITS-1:0]  row_mem [NODE_COUNT];

    logic                 ptr_we, ptr_re;
    logic [PTR_BITS-1:0]  ptr_waddr, ptr_raddr;
    logic [NODE_BITS-1:0] ptr_wdata, ptr_q;
    logic                 row_we, row_re;
    logic [NODE_BITS-1:0] row_waddr, row_raddr;
    logic [ROW_BITS-1:0]  row_wdata, row_q;

    // control and cached state
    state_t                state_reg, state_next;
    logic [NODE_BITS-1:0]  cur_reg, cur_next;
    logic                  missing_reg, missing_next;
    logic                  ovf_reg, ovf_next;
    logic [USED_BITS-1:0]  used_reg, used_next;
    logic [RADIX-1:0]      root_present_reg, root_present_next;
    logic [COUNT_BITS-1:0] root_count_reg, root_count_next;
    logic [RADIX-1:0]      cache_present_reg, cache_present_next;
    logic [COUNT_BITS-1:0] cache_count_reg, cache_count_next;
    logic                  last_reg, last_next;
    logic                  insert_reg, insert_next;

    // output register and parked result
    logic out_valid_reg, out_valid_next;
    logic out_found_reg, out_found_next;
    logic out_unique_reg, out_unique_next;
    logic out_ovf_reg, out_ovf_next;
    logic hold_found_reg, hold_found_next;
    logic hold_unique_reg, hold_unique_next;
    logic hold_ovf_reg, hold_ovf_next;

    // end-of-string result
    logic                  fin_valid;
    logic [COUNT_BITS-1:0] end_count;
    logic                  fin_found, fin_unique;

    logic                  out_free;
    logic                  accept;
    logic [RADIX-1:0]      cur_present;
    logic [COUNT_BITS-1:0] cur_count;
    logic [PTR_BITS-1:0]   edge_addr;
    logic [RADIX-1:0]      row_q_present;
    logic [COUNT_BITS-1:0] row_q_count;
    logic [COUNT_BITS-1:0] child_count;

    assign din.ready       = (state_reg == ST_IDLE);
    assign accept          = din.valid && din.ready;
    assign out_free        = !out_valid_reg || dout.ready;

    assign dout.valid      = out_valid_reg;
    assign dout.found      = out_found_reg;
    assign dout.unique_res = out_unique_reg;
    assign dout.overflow   = out_ovf_reg;

    // root row is held in flops; other nodes use the cached row
    assign cur_present = (cur_reg == '0) ? root_present_reg : cache_present_reg;
    assign cur_count   = (cur_reg == '0) ? root_count_reg   : cache_count_reg;

    // edge slot = cur * 10 + digit
    assign edge_addr = PTR_BITS'({cur_reg, 3'b000}) + PTR_BITS'({cur_reg, 1'b0})
                     + PTR_BITS'(din.digit);

    assign row_q_present = row_q[ROW_BITS-1 -: RADIX];
    assign row_q_count   = row_q[COUNT_BITS-1:0];
    assign child_count   = sat_inc(row_q_count);

    always_comb
    begin
        state_next         = state_reg;
        cur_next           = cur_reg;
        missing_next       = missing_reg;
        ovf_next           = ovf_reg;
        used_next          = used_reg;
        root_present_next  = root_present_reg;
        root_count_next    = root_count_reg;
        cache_present_next = cache_present_reg;
        cache_count_next   = cache_count_reg;
        last_next          = last_reg;
        insert_next        = insert_reg;

        out_valid_next     = out_valid_reg && !dout.ready;
        out_found_next     = out_found_reg;
        out_unique_next    = out_unique_reg;
        out_ovf_next       = out_ovf_reg;
        hold_found_next    = hold_found_reg;
        hold_unique_next   = hold_unique_reg;
        hold_ovf_next      = hold_ovf_reg;

        ptr_we    = 1'b0;
        ptr_waddr = edge_addr;
        ptr_wdata = used_reg[NODE_BITS-1:0];
        ptr_re    = 1'b0;
        ptr_raddr = edge_addr;
        row_we    = 1'b0;
        row_waddr = cur_reg;
        row_wdata = {cache_present_reg, cache_count_reg};
        row_re    = 1'b0;
        row_raddr = ptr_q;

        fin_valid = 1'b0;
        end_count = cur_count;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    last_next   = din.last;
                    insert_next = (din.cmd == CMD_INSERT);
                    unique case (din.cmd)
                        CMD_CLEAR:
                        begin
                            cur_next          = '0;
                            missing_next      = 1'b0;
                            ovf_next          = 1'b0;
                            used_next         = USED_BITS'(1);
                            root_present_next = '0;
                            root_count_next   = '0;
                        end
                        CMD_INSERT, CMD_QUERY:
                        begin
                            // string start on insert bumps the root
                            if (din.cmd == CMD_INSERT && cur_reg == '0 && !missing_reg)
                                root_count_next = sat_inc(root_count_reg);

                            if (missing_reg)
                            begin
                                fin_valid = din.last;
                            end
                            else if (din.digit > DIGIT_MAX)
                            begin
                                missing_next = 1'b1;
                                fin_valid    = din.last;
                            end
                            else if (cur_present[din.digit])
                            begin
                                ptr_re     = 1'b1;
                                state_next = ST_PTR;
                            end
                            else if (din.cmd == CMD_QUERY)
                            begin
                                missing_next = 1'b1;
                                fin_valid    = din.last;
                            end
                            else if (used_reg < USED_BITS'(NODE_COUNT))
                            begin
                                // new child: link it, mark parent, move cursor
                                ptr_we = 1'b1;
                                if (cur_reg == '0)
                                begin
                                    root_present_next[din.digit] = 1'b1;
                                end
                                else
                                begin
                                    row_we    = 1'b1;
                                    row_wdata = {cache_present_reg | (RADIX'(1) << din.digit),
                                                 cache_count_reg};
                                end
                                cur_next           = used_reg[NODE_BITS-1:0];
                                cache_present_next = '0;
                                cache_count_next   = COUNT_BITS'(1);
                                used_next          = used_reg + USED_BITS'(1);
                                state_next         = ST_ALLOC;
                            end
                            else
                            begin
                                ovf_next     = 1'b1;
                                missing_next = 1'b1;
                                fin_valid    = din.last;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_ALLOC:
            begin
                row_we     = 1'b1;
                row_wdata  = {cache_present_reg, cache_count_reg};
                end_count  = cache_count_reg;
                fin_valid  = last_reg;
                state_next = ST_IDLE;
            end
            ST_PTR:
            begin
                row_re     = 1'b1;
                cur_next   = ptr_q;
                state_next = ST_ROW;
            end
            ST_ROW:
            begin
                cache_present_next = row_q_present;
                if (insert_reg)
                begin
                    row_we           = 1'b1;
                    row_wdata        = {row_q_present, child_count};
                    cache_count_next = child_count;
                end
                else
                begin
                    cache_count_next = row_q_count;
                end
                end_count  = cache_count_next;
                fin_valid  = last_reg;
                state_next = ST_IDLE;
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_found_next  = hold_found_reg;
                    out_unique_next = hold_unique_reg;
                    out_ovf_next    = hold_ovf_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        fin_found  = !missing_next;
        fin_unique = fin_found && (end_count == COUNT_BITS'(1));

        if (fin_valid)
        begin
            cur_next     = '0;
            missing_next = 1'b0;
            if (out_free)
            begin
                out_valid_next  = 1'b1;
                out_found_next  = fin_found;
                out_unique_next = fin_unique;
                out_ovf_next    = ovf_next;
                state_next      = ST_IDLE;
            end
            else
            begin
                hold_found_next  = fin_found;
                hold_unique_next = fin_unique;
                hold_ovf_next    = ovf_next;
                state_next       = ST_HOLD;
            end
        end
    end

    // child pointer memory
    always_ff @(posedge clk)
    begin
        if (ptr_we)
            ptr_mem[ptr_waddr] <= ptr_wdata;
        if (ptr_re)
            ptr_q <= ptr_mem[ptr_raddr];
    end

    // node row memory
    always_ff @(posedge clk)
    begin
        if (row_we)
            row_mem[row_waddr] <= row_wdata;
        if (row_re)
            row_q <= row_mem[row_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            cur_reg          <= '0;
            missing_reg      <= 1'b0;
            ovf_reg          <= 1'b0;
            used_reg         <= USED_BITS'(1);
            root_present_reg <= '0;
            root_count_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cur_reg          <= cur_next;
            missing_reg      <= missing_next;
            ovf_reg          <= ovf_next;
            used_reg         <= used_next;
            root_present_reg <= root_present_next;
            root_count_reg   <= root_count_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload and cache registers
    always_ff @(posedge clk)
    begin
        cache_present_reg <= cache_present_next;
        cache_count_reg   <= cache_count_next;
        last_reg          <= last_next;
        insert_reg        <= insert_next;
        out_found_reg     <= out_found_next;
        out_unique_reg    <= out_unique_next;
        out_ovf_reg       <= out_ovf_next;
        hold_found_reg    <= hold_found_next;
        hold_unique_reg   <= hold_unique_next;
        hold_ovf_reg      <= hold_ovf_next;
    end

endmodule

/* tb/sv/digit_trie_prefix_counter_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// digit_trie_prefix_counter_test
// Self-checking bench for the decimal digit trie prefix counter. Digit beats
// go in over din. A trie model kept in the bench predicts the flags of every
// string-end beat, and each dout beat is checked against the oldest of them.
// ----------------------------------------------------------------------------
module digit_trie_prefix_counter_test;

    import dtpc_pkg::*;

    // Result flags of one finished string, in arrival order.
    typedef struct packed {
        logic found;
        logic unique_res;
        logic overflow;
    } answer_t;

    // A short digit string for the random part (up to six digits).
    typedef struct packed {
        logic [2:0]                  len;
        logic [5:0][DIGIT_BITS-1:0]  digits;
    } word_t;

    logic clk;
    logic rst_n;

    dtpc_in_if  din_bus ();
    dtpc_out_if dout_bus ();

    digit_trie_prefix_counter u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_bus),
        .dout  (dout_bus)
    );

    // ------------------------------------------------------------------
    // Trie model state: a node pool that mirrors the block's memories
    // ------------------------------------------------------------------
    bit [RADIX-1:0]      row_present [NODE_COUNT];
    bit [COUNT_BITS-1:0] row_count   [NODE_COUNT];
    bit [NODE_BITS-1:0]  child_ptr   [PTR_DEPTH];
    bit [NODE_BITS-1:0]  walk_node;
    bit [USED_BITS-1:0]  nodes_used;
    bit                  walk_lost;     // current string has left the trie
    bit                  pool_full;     // sticky until the next clear

    answer_t answers_due [$];

    int  err_count  = 0;
    int  beats_sent = 0;
    int  burst_left = 0;
    bit  pace_on    = 1'b1;             // 0: sender and receiver flat out

    int   sink_mode  = 0;
    int   sink_phase = 0;
    logic sink_next;

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------
    // Trie model
    // ------------------------------------------------------------------
    function automatic void trie_clear();
        row_present[0] = '0;
        row_count[0]   = '0;
        walk_node      = '0;
        nodes_used     = USED_BITS'(1);
        walk_lost      = 1'b0;
        pool_full      = 1'b0;
    endfunction

    // Counts stick at all-ones.
    function automatic void count_bump(bit [NODE_BITS-1:0] n);
        if (row_count[n] != '1)
            row_count[n] = row_count[n] + 1'b1;
    endfunction

    // Apply one accepted beat; a string end queues its answer.
    function automatic void trie_apply(cmd_t op, logic [DIGIT_BITS-1:0] dg, logic fin);
        bit [NODE_BITS-1:0] node;
        int                 slot;
        answer_t            ans;
        node = walk_node;
        slot = int'(node) * RADIX + int'(dg);
        case (op)
            CMD_CLEAR:
            begin
                trie_clear();
                return;
            end
            CMD_NOP:
                return;
            CMD_INSERT:
            begin
                // a string start also counts at the root
                if (node == 0 && !walk_lost)
                    count_bump('0);
                if (!walk_lost)
                begin
                    if (dg > DIGIT_MAX)
                        walk_lost = 1'b1;
                    else if (row_present[node][dg])
                        node = child_ptr[slot];
                    else if (nodes_used < NODE_COUNT)
                    begin
                        row_present[nodes_used[NODE_BITS-1:0]] = '0;
                        row_count[nodes_used[NODE_BITS-1:0]]   = '0;
                        child_ptr[slot]       = nodes_used[NODE_BITS-1:0];
                        row_present[node][dg] = 1'b1;
                        node       = nodes_used[NODE_BITS-1:0];
                        nodes_used = nodes_used + 1'b1;
                    end
                    else
                    begin
                        // pool exhausted: drop the rest of this string
                        pool_full = 1'b1;
                        walk_lost = 1'b1;
                    end
                    if (!walk_lost)
                        count_bump(node);
                end
            end
            default:
            begin
                if (!walk_lost)
                begin
                    if (dg > DIGIT_MAX || !row_present[node][dg])
                        walk_lost = 1'b1;
                    else
                        node = child_ptr[slot];
                end
            end
        endcase
        walk_node = node;
        if (fin)
        begin
            ans.found      = !walk_lost;
            ans.unique_res = !walk_lost && row_count[node] == 1;
            ans.overflow   = pool_full;
            answers_due.push_back(ans);
            walk_node = '0;
            walk_lost = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender: bursts of beats with random gaps between them. valid stays
    // high across back-to-back beats and only drops for a gap.
    // ------------------------------------------------------------------
    task automatic send_beat(cmd_t op, logic [DIGIT_BITS-1:0] dg, logic fin);
        int gap;
        if (pace_on && burst_left == 0)
        begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 14) : $urandom_range(1, 4);
            din_bus.valid <= 1'b0;
            din_bus.cmd   <= CMD_NOP;
            din_bus.digit <= DIGIT_BITS'($urandom_range(0, 15));
            din_bus.last  <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        din_bus.valid <= 1'b1;
        din_bus.cmd   <= op;
        din_bus.digit <= dg;
        din_bus.last  <= fin;
        do
            @(posedge clk);
        while (!din_bus.ready);
        trie_apply(op, dg, fin);
        beats_sent++;
        if (burst_left > 0)
            burst_left--;
    endtask

    // Send a word digit by digit; mixed flips some beats to query,
    // closed marks the final digit as the string end.
    task automatic send_word(cmd_t op, word_t w, bit mixed, bit closed);
        cmd_t c;
        for (int i = 0; i < int'(w.len); i++)
        begin
            c = op;
            if (mixed && $urandom_range(0, 1) == 1)
                c = CMD_QUERY;
            send_beat(c, w.digits[i], closed && i == int'(w.len) - 1);
        end
    endtask

    // Mostly a narrow alphabet so strings share prefixes; now and then a
    // full-range digit, the odd one above nine.
    function automatic word_t random_word();
        word_t w;
        int    pick;
        w.len = 3'($urandom_range(1, 6));
        for (int i = 0; i < 6; i++)
        begin
            pick = $urandom_range(0, 15);
            if (pick == 0)
                w.digits[i] = DIGIT_BITS'($urandom_range(0, 15));
            else if (pick < 4)
                w.digits[i] = DIGIT_BITS'($urandom_range(0, 9));
            else
                w.digits[i] = DIGIT_BITS'($urandom_range(0, 3));
        end
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Receiver: ready follows a mode that is redrawn at random intervals -
    // always ready, mostly ready, mostly stalled, or toggling with the phase counter.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (sink_phase == 0)
        begin
            sink_mode  = $urandom_range(0, 3);
            sink_phase = $urandom_range(8, 80);
        end
        else
            sink_phase--;
        if (!pace_on)
            sink_next = 1'b1;
        else
            case (sink_mode)
                0:       sink_next = 1'b1;
                1:       sink_next = ($urandom_range(0, 3) != 0);
                2:       sink_next = ($urandom_range(0, 3) == 0);
                default: sink_next = sink_phase[2];
            endcase
        dout_bus.ready <= sink_next;
    end

    // ------------------------------------------------------------------
    // Result checker: every dout beat against the oldest answer due
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && dout_bus.valid && dout_bus.ready)
        begin
            if (answers_due.size() == 0)
            begin
                $error("result beat with no answer due");
                err_count++;
            end
            else
            begin
                want = answers_due.pop_front();
                if (dout_bus.found !== want.found)
                begin
                    $error("found: expected %0b, actual %0b", want.found, dout_bus.found);
                    err_count++;
                end
                if (dout_bus.unique_res !== want.unique_res)
                begin
                    $error("unique_res: expected %0b, actual %0b",
                           want.unique_res, dout_bus.unique_res);
                    err_count++;
                end
                if (dout_bus.overflow !== want.overflow)
                begin
                    $error("overflow: expected %0b, actual %0b",
                           want.overflow, dout_bus.overflow);
                    err_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hits, misses, shared prefixes and the digit extremes 0 and 9.
    task automatic test_directed_walks();
        send_beat(CMD_CLEAR,  4'd9, 1'b1);      // clear ignores digit and last
        send_beat(CMD_INSERT, 4'd0, 1'b0);
        send_beat(CMD_INSERT, 4'd9, 1'b1);      // new string: found, unique
        send_beat(CMD_INSERT, 4'd0, 1'b1);      // shares prefix, not unique
        send_beat(CMD_QUERY,  4'd0, 1'b0);
        send_beat(CMD_QUERY,  4'd9, 1'b1);      // unique leaf
        send_beat(CMD_QUERY,  4'd0, 1'b1);      // count two
        send_beat(CMD_QUERY,  4'd9, 1'b1);      // no such path
        send_beat(CMD_QUERY,  4'd0, 1'b0);
        send_beat(CMD_QUERY,  4'd9, 1'b0);
        send_beat(CMD_QUERY,  4'd9, 1'b1);      // runs off a leaf
    endtask

    // Digits above nine, ignored command, mixed and cut-off strings.
    task automatic test_odd_beats();
        send_beat(CMD_INSERT, 4'd1,  1'b0);
        send_beat(CMD_INSERT, 4'd15, 1'b1);     // insert drops, no overflow
        send_beat(CMD_QUERY,  4'd10, 1'b1);     // query of a non-digit
        send_beat(CMD_QUERY,  4'd1,  1'b0);
        send_beat(CMD_QUERY,  4'd12, 1'b1);
        send_beat(CMD_INSERT, 4'd3,  1'b0);
        send_beat(CMD_NOP,    4'd15, 1'b1);     // no effect mid-string
        send_beat(CMD_INSERT, 4'd4,  1'b1);
        send_beat(CMD_INSERT, 4'd0,  1'b0);     // insert then query, one string
        send_beat(CMD_QUERY,  4'd9,  1'b1);
        send_beat(CMD_INSERT, 4'd5,  1'b0);
        send_beat(CMD_CLEAR,  4'd6,  1'b0);     // clear mid-string
        send_beat(CMD_QUERY,  4'd5,  1'b1);     // gone with the clear
        send_beat(CMD_INSERT, 4'd5,  1'b1);
    endtask

    // Drive one path past the counter range; root and leaf both stick.
    task automatic test_count_saturation();
        pace_on = 1'b0;
        send_beat(CMD_CLEAR, 4'd0, 1'b0);
        for (int i = 0; i <= (1 << COUNT_BITS); i++)
            send_beat(CMD_INSERT, 4'd7, 1'b1);
        send_beat(CMD_QUERY,  4'd7, 1'b1);
        send_beat(CMD_INSERT, 4'd7, 1'b0);
        send_beat(CMD_INSERT, 4'd8, 1'b1);      // fresh leaf under a full count
        pace_on = 1'b1;
    endtask

    // One long chain of zeros uses up the pool; overflow stays until clear.
    task automatic test_pool_exhaustion();
        pace_on = 1'b0;
        send_beat(CMD_CLEAR, 4'd0, 1'b0);
        for (int i = 0; i < NODE_COUNT; i++)
            send_beat(CMD_INSERT, 4'd0, i == NODE_COUNT - 1);
        pace_on = 1'b1;
        send_beat(CMD_QUERY,  4'd0, 1'b1);
        send_beat(CMD_INSERT, 4'd9, 1'b1);      // no node left
        send_beat(CMD_INSERT, 4'd0, 1'b0);
        send_beat(CMD_INSERT, 4'd0, 1'b1);      // existing path still walks
        send_beat(CMD_CLEAR,  4'd0, 1'b1);
        send_beat(CMD_INSERT, 4'd9, 1'b1);      // overflow cleared
    endtask

    // Mostly well-formed inserts and queries of earlier strings, with
    // mixed strings, open-ended strings, ignored beats and the odd clear.
    task automatic test_random_strings();
        word_t w;
        word_t kept [$];
        int    r;
        int    goal;
        goal = beats_sent + 650;
        while (beats_sent < goal)
        begin
            r = $urandom_range(0, 99);
            w = random_word();
            if (r < 42)
            begin
                send_word(CMD_INSERT, w, 1'b0, 1'b1);
                if (kept.size() < 48)
                    kept.push_back(w);
            end
            else if (r < 78)
            begin
                if (kept.size() > 0 && $urandom_range(0, 3) != 0)
                begin
                    w     = kept[$urandom_range(0, kept.size() - 1)];
                    w.len = 3'($urandom_range(1, int'(w.len)));
                end
                send_word(CMD_QUERY, w, 1'b0, 1'b1);
            end
            else if (r < 86)
                send_word(CMD_INSERT, w, 1'b1, 1'b1);
            else if (r < 94)
                send_beat(CMD_NOP, DIGIT_BITS'($urandom_range(0, 15)),
                          1'($urandom_range(0, 1)));
            else if (r < 98)
                send_word($urandom_range(0, 1) ? CMD_INSERT : CMD_QUERY, w, 1'b0, 1'b0);
            else
            begin
                send_beat(CMD_CLEAR, DIGIT_BITS'($urandom_range(0, 15)),
                          1'($urandom_range(0, 1)));
                kept.delete();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        din_bus.valid  = 1'b0;
        din_bus.cmd    = CMD_NOP;
        din_bus.digit  = '0;
        din_bus.last   = 1'b0;
        dout_bus.ready = 1'b0;
        trie_clear();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_walks();
        test_odd_beats();
        test_count_saturation();
        test_pool_exhaustion();
        test_random_strings();

        din_bus.valid <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (answers_due.size() != 0)
        begin
            $error("%0d answers never arrived", answers_due.size());
            err_count++;
        end
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog: ends the run as a failure if the tests have not finished.
    initial
    begin
        #4000000;
        $display("status: fail");
        $finish;
    end

endmodule
